### hdl/meue_pkg.sv
// meue_pkg: shared types, constants and the helper function of the mesh unique edge extractor
// no dependencies

package meue_pkg;

    localparam int DEF_MAX_RECORDS = 1024;
    localparam int DEF_MAX_FACES   = 256;
    localparam int VERTEX_BITS     = 10;

    localparam int VERTEX_W = 10;
    localparam int OFS_W    = 14;
    localparam int KEY_W    = 2 * OFS_W;
    localparam int STRIDE_W = 5;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 5'd6;
    localparam logic [VERTEX_W-1:0] VERTEX_MASK  = VERTEX_W'((64'd1 << VERTEX_BITS) - 64'd1);

    localparam logic KIND_CORNER = 1'b0;
    localparam logic KIND_PULL   = 1'b1;

    localparam logic [1:0] REC_EDGE  = 2'd0;
    localparam logic [1:0] REC_ENTRY = 2'd1;
    localparam logic [1:0] REC_DONE  = 2'd2;

    typedef struct packed {
        logic                kind;
        logic [VERTEX_W-1:0] vertex;
        logic                face_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       record_type;
        logic [OFS_W-1:0] endpoint_low;
        logic [OFS_W-1:0] endpoint_high;
        logic [7:0]       face_number;
        logic [9:0]       edge_number;
        logic [9:0]       slot;
        logic [10:0]      edge_total;
        logic             overflowed;
    } out_item_t;

    typedef struct packed {
        logic load_corner;
        logic load_second;
        logic close_face;
        logic sort_init;
        logic sort_rd_i;
        logic sort_take;
        logic sort_rd_j;
        logic sort_shift;
        logic sort_place;
        logic id_init;
        logic id_rd;
        logic id_wr;
        logic clr_init;
        logic clr_step;
        logic serve_init;
        logic ed_rd;
        logic ed_out;
        logic rp_clear;
        logic en_rd;
        logic en_fill_rd;
        logic en_out;
        logic dn_out;
    } cmd_t;

    typedef struct packed {
        logic needs_second;
        logic i_done;
        logic j_zero;
        logic greater;
        logic clr_last;
        logic ed_avail;
        logic en_avail;
        logic out_free;
    } sts_t;

    // clamp the stride to 1..16 and wrap the product to the offset width
    function automatic logic [OFS_W-1:0] scale(input logic [VERTEX_W-1:0] v,
                                                input logic [STRIDE_W-1:0] stride);
        logic [STRIDE_W-1:0]       s;
        logic [VERTEX_W+STRIDE_W-1:0] p;
        if (stride == '0) begin
            s = 5'd1;
        end else if (stride > 5'd16) begin
            s = 5'd16;
        end else begin
            s = stride;
        end
        p = (VERTEX_W+STRIDE_W)'(v) * (VERTEX_W+STRIDE_W)'(s);
        return p[OFS_W-1:0];
    endfunction

endpackage

### hdl/mesh_unique_edge_extractor.sv
// mesh_unique_edge_extractor: top level of the mesh unique edge extractor
// depends on meue_pkg, meue_controller and meue_datapath
//
// Usage: corners (kind 0) stream in on s_*, face_end marks the last corner of a face.
// A face-closing corner of an open face adds its closing edges through the single store
// write port, so s_ready drops in the ST_LOAD2 step. Corners produce no transfer on m_*.
// The first pull (kind 1) closes an open face, then runs an insertion sort over the
// record store, a merge pass that numbers the unique edges, and a clearing pass over all
// MAX_FACES face counters before its result is loaded. Later pulls each move the next
// record to the output register.
// Pulls return unique edges, then face-edge entries, then done records, one per pull.
// The output register holds a result while m_ready is low; the block still takes the
// next transfer on s_* and waits with it until the register frees.
// cfg_* writes the vertex stride, always ready; write only while idle.
// Reset (aresetn low, synchronous) empties the store, sets the stride to 6 and returns
// to loading.

module mesh_unique_edge_extractor #(
    parameter int MAX_RECORDS = meue_pkg::DEF_MAX_RECORDS,
    parameter int MAX_FACES   = meue_pkg::DEF_MAX_FACES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [meue_pkg::STRIDE_W-1:0] cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  meue_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output meue_pkg::out_item_t           m_data
);

    meue_pkg::cmd_t cmd;
    meue_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    meue_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_data.kind),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    meue_datapath #(
        .MAX_RECORDS (MAX_RECORDS),
        .MAX_FACES   (MAX_FACES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_data   (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### hdl/meue_datapath.sv
// meue_datapath: record store, sort and merge datapath, face fill counters and output register
// depends on meue_pkg; driven by meue_controller through cmd_t and sts_t

module meue_datapath #(
    parameter int MAX_RECORDS = meue_pkg::DEF_MAX_RECORDS,
    parameter int MAX_FACES   = meue_pkg::DEF_MAX_FACES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [meue_pkg::STRIDE_W-1:0] cfg_data,
    input  meue_pkg::in_item_t            in_data,
    input  meue_pkg::cmd_t                cmd,
    output meue_pkg::sts_t                sts,
    output logic                          m_valid,
    input  logic                          m_ready,
    output meue_pkg::out_item_t           m_data
);

    localparam int IDX_W  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int FACE_W = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int FCNT_W = (MAX_FACES > 1) ? $clog2(MAX_FACES + 1) : 1;
    localparam int KEY_W  = meue_pkg::KEY_W;
    localparam int OFS_W  = meue_pkg::OFS_W;
    localparam int VW     = meue_pkg::VERTEX_W;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [FACE_W-1:0] face;
    } rec_t;

    rec_t              store_mem [MAX_RECORDS];
    logic [IDX_W-1:0]  eid_mem   [MAX_RECORDS];
    logic [KEY_W-1:0]  uniq_mem  [MAX_RECORDS];
    logic [CNT_W-1:0]  fill_mem  [MAX_FACES];

    logic [meue_pkg::STRIDE_W-1:0] stride_reg;
    logic [CNT_W-1:0]  rec_count_reg;
    logic [FCNT_W-1:0] face_count_reg;
    logic [VW-1:0]     first_reg;
    logic [VW-1:0]     prev_reg;
    logic [VW-1:0]     pend_reg;
    logic              in_face_reg;
    logic              ovf_reg;
    logic [CNT_W-1:0]  i_reg;
    logic [CNT_W-1:0]  j_reg;
    rec_t              key_reg;
    logic [CNT_W-1:0]  ucnt_reg;
    logic [KEY_W-1:0]  prev_key_reg;
    logic [CNT_W-1:0]  rp_reg;
    logic [FACE_W-1:0] clr_reg;
    rec_t              store_rd_reg;
    logic [IDX_W-1:0]  eid_rd_reg;
    logic [KEY_W-1:0]  uniq_rd_reg;
    logic [CNT_W-1:0]  fill_rd_reg;
    logic              out_valid_reg;
    meue_pkg::out_item_t out_reg;
    meue_pkg::out_item_t out_next;

    logic [VW-1:0]    v;
    logic             face_ok;
    logic             room;
    logic             add_en;
    logic             add_wr;
    logic [VW-1:0]    add_a;
    logic [VW-1:0]    add_b;
    logic [OFS_W-1:0] sa;
    logic [OFS_W-1:0] sb;
    logic [KEY_W-1:0] add_key;
    logic             id_new;

    logic             st_we;
    logic [IDX_W-1:0] st_waddr;
    rec_t             st_wdata;
    logic             st_re;
    logic [IDX_W-1:0] st_raddr;
    logic [CNT_W-1:0] j_dec;

    logic              fill_we;
    logic [FACE_W-1:0] fill_waddr;
    logic [CNT_W-1:0]  fill_wdata;

    assign v       = in_data.vertex & meue_pkg::VERTEX_MASK;
    assign face_ok = face_count_reg < FCNT_W'(MAX_FACES);
    assign room    = rec_count_reg < CNT_W'(MAX_RECORDS);
    assign j_dec   = j_reg - CNT_W'(1);
    assign id_new  = (i_reg == '0) || (store_rd_reg.key != prev_key_reg);

    // edge record source
    always_comb begin
        add_en = 1'b0;
        add_a  = v;
        add_b  = v;
        if (cmd.load_corner && face_ok) begin
            if (!in_face_reg) begin
                add_en = in_data.face_end;
            end else begin
                add_en = 1'b1;
                add_a  = prev_reg;
            end
        end
        if (cmd.load_second) begin
            add_en = 1'b1;
            add_a  = pend_reg;
            add_b  = first_reg;
        end
        if (cmd.close_face && in_face_reg) begin
            add_en = 1'b1;
            add_a  = prev_reg;
            add_b  = first_reg;
        end
    end

    assign sa      = meue_pkg::scale(add_a, stride_reg);
    assign sb      = meue_pkg::scale(add_b, stride_reg);
    assign add_key = (sa < sb) ? {sa, sb} : {sb, sa};
    assign add_wr  = add_en && room;

    // store port select
    always_comb begin
        st_we    = 1'b0;
        st_waddr = rec_count_reg[IDX_W-1:0];
        st_wdata = '{key: add_key, face: face_count_reg[FACE_W-1:0]};
        if (add_wr) begin
            st_we = 1'b1;
        end else if (cmd.sort_shift) begin
            st_we    = 1'b1;
            st_waddr = j_reg[IDX_W-1:0];
            st_wdata = store_rd_reg;
        end else if (cmd.sort_place) begin
            st_we    = 1'b1;
            st_waddr = j_reg[IDX_W-1:0];
            st_wdata = key_reg;
        end
        st_re    = cmd.sort_rd_i || cmd.sort_rd_j || cmd.id_rd || cmd.en_rd;
        st_raddr = i_reg[IDX_W-1:0];
        if (cmd.sort_rd_j) begin
            st_raddr = j_dec[IDX_W-1:0];
        end else if (cmd.en_rd) begin
            st_raddr = rp_reg[IDX_W-1:0];
        end
    end

    always_comb begin
        fill_we    = cmd.clr_step || cmd.en_out;
        fill_waddr = cmd.clr_step ? clr_reg : store_rd_reg.face;
        fill_wdata = cmd.clr_step ? '0 : fill_rd_reg + CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_mem[st_waddr] <= st_wdata;
        end
        if (st_re) begin
            store_rd_reg <= store_mem[st_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.id_wr) begin
            eid_mem[i_reg[IDX_W-1:0]] <= id_new ? ucnt_reg[IDX_W-1:0]
                                                : IDX_W'(ucnt_reg - CNT_W'(1));
        end
        if (cmd.en_rd) begin
            eid_rd_reg <= eid_mem[rp_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.id_wr && id_new) begin
            uniq_mem[ucnt_reg[IDX_W-1:0]] <= store_rd_reg.key;
        end
        if (cmd.ed_rd) begin
            uniq_rd_reg <= uniq_mem[rp_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (fill_we) begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        if (cmd.en_fill_rd) begin
            fill_rd_reg <= fill_mem[store_rd_reg.face];
        end
    end

    // loading state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stride_reg     <= meue_pkg::STRIDE_RESET;
            rec_count_reg  <= '0;
            face_count_reg <= '0;
            first_reg      <= '0;
            prev_reg       <= '0;
            pend_reg       <= '0;
            in_face_reg    <= 1'b0;
            ovf_reg        <= 1'b0;
        end else begin
            if (cfg_valid) begin
                stride_reg <= cfg_data;
            end
            if (add_wr) begin
                rec_count_reg <= rec_count_reg + CNT_W'(1);
            end
            if (add_en && !room) begin
                ovf_reg <= 1'b1;
            end
            if (cmd.load_corner) begin
                if (!face_ok) begin
                    ovf_reg <= 1'b1;
                end else if (!in_face_reg) begin
                    first_reg <= v;
                    prev_reg  <= v;
                    if (in_data.face_end) begin
                        face_count_reg <= face_count_reg + FCNT_W'(1);
                    end else begin
                        in_face_reg <= 1'b1;
                    end
                end else begin
                    prev_reg <= v;
                    pend_reg <= v;
                end
            end
            if (cmd.load_second || (cmd.close_face && in_face_reg)) begin
                face_count_reg <= face_count_reg + FCNT_W'(1);
                in_face_reg    <= 1'b0;
            end
        end
    end

    // sort, merge and read-out counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg        <= '0;
            j_reg        <= '0;
            ucnt_reg     <= '0;
            rp_reg       <= '0;
            clr_reg      <= '0;
            prev_key_reg <= '0;
        end else begin
            if (cmd.sort_init) begin
                i_reg <= CNT_W'(1);
            end
            if (cmd.sort_take) begin
                j_reg <= i_reg;
            end
            if (cmd.sort_shift) begin
                j_reg <= j_dec;
            end
            if (cmd.sort_place || cmd.id_wr) begin
                i_reg <= i_reg + CNT_W'(1);
            end
            if (cmd.id_init) begin
                i_reg    <= '0;
                ucnt_reg <= '0;
            end
            if (cmd.id_wr) begin
                prev_key_reg <= store_rd_reg.key;
                if (id_new) begin
                    ucnt_reg <= ucnt_reg + CNT_W'(1);
                end
            end
            if (cmd.clr_init) begin
                clr_reg <= '0;
            end
            if (cmd.clr_step) begin
                clr_reg <= clr_reg + FACE_W'(1);
            end
            if (cmd.serve_init || cmd.rp_clear) begin
                rp_reg <= '0;
            end
            if (cmd.ed_out || cmd.en_out) begin
                rp_reg <= rp_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sort_take) begin
            key_reg <= store_rd_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.ed_out || cmd.en_out || cmd.dn_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_comb begin
        out_next = '0;
        if (cmd.ed_out) begin
            out_next.record_type   = meue_pkg::REC_EDGE;
            out_next.endpoint_low  = uniq_rd_reg[KEY_W-1:OFS_W];
            out_next.endpoint_high = uniq_rd_reg[OFS_W-1:0];
            out_next.edge_number   = 10'(rp_reg);
        end else if (cmd.en_out) begin
            out_next.record_type = meue_pkg::REC_ENTRY;
            out_next.face_number = 8'(store_rd_reg.face);
            out_next.edge_number = 10'(eid_rd_reg);
            out_next.slot        = 10'(fill_rd_reg);
        end else begin
            out_next.record_type = meue_pkg::REC_DONE;
            out_next.edge_total  = 11'(ucnt_reg);
            out_next.overflowed  = ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ed_out || cmd.en_out || cmd.dn_out) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign sts.needs_second = in_face_reg && in_data.face_end && face_ok;
    assign sts.i_done       = i_reg >= rec_count_reg;
    assign sts.j_zero       = j_reg == '0;
    assign sts.greater      = store_rd_reg.key > key_reg.key;
    assign sts.clr_last     = clr_reg == FACE_W'(MAX_FACES - 1);
    assign sts.ed_avail     = rp_reg < ucnt_reg;
    assign sts.en_avail     = rp_reg < rec_count_reg;
    assign sts.out_free     = !out_valid_reg || m_ready;

`ifndef NO_ASSERTIONS
    a_rec_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rec_count_reg <= CNT_W'(MAX_RECORDS))
        else $error("record count beyond store depth");
    a_face_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        face_count_reg <= FCNT_W'(MAX_FACES))
        else $error("face count beyond limit");
    a_uniq_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ucnt_reg <= rec_count_reg)
        else $error("more unique edges than records");
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.ed_out || cmd.en_out || cmd.dn_out) |-> (!out_valid_reg || m_ready))
        else $error("result loaded over a pending transfer");
`endif

endmodule

### hdl/meue_controller.sv
// meue_controller: sequencer for loading, close, insertion sort, merge, clear and read-out
// depends on meue_pkg; drives meue_datapath through cmd_t and reads sts_t

module meue_controller (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_kind,
    output logic           s_ready,
    input  meue_pkg::sts_t sts,
    output meue_pkg::cmd_t cmd
);

    localparam logic [4:0] ST_LOAD     = 5'd0;
    localparam logic [4:0] ST_LOAD2    = 5'd1;
    localparam logic [4:0] ST_CLOSE    = 5'd2;
    localparam logic [4:0] ST_SORT_I   = 5'd3;
    localparam logic [4:0] ST_SORT_K   = 5'd4;
    localparam logic [4:0] ST_SORT_RD  = 5'd5;
    localparam logic [4:0] ST_SORT_CMP = 5'd6;
    localparam logic [4:0] ST_ID_RD    = 5'd7;
    localparam logic [4:0] ST_ID_WR    = 5'd8;
    localparam logic [4:0] ST_CLR      = 5'd9;
    localparam logic [4:0] ST_ED_CHK   = 5'd10;
    localparam logic [4:0] ST_ED_OUT   = 5'd11;
    localparam logic [4:0] ST_EN_CHK   = 5'd12;
    localparam logic [4:0] ST_EN_F     = 5'd13;
    localparam logic [4:0] ST_EN_OUT   = 5'd14;
    localparam logic [4:0] ST_DN_OUT   = 5'd15;
    localparam logic [4:0] ST_WAIT     = 5'd16;

    localparam logic [1:0] PH_EDGES   = 2'd0;
    localparam logic [1:0] PH_ENTRIES = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_kind == meue_pkg::KIND_PULL) begin
                        state_next = ST_CLOSE;
                    end else begin
                        cmd.load_corner = 1'b1;
                        if (sts.needs_second) begin
                            state_next = ST_LOAD2;
                        end
                    end
                end
            end
            ST_LOAD2: begin
                cmd.load_second = 1'b1;
                state_next      = ST_LOAD;
            end
            ST_CLOSE: begin
                cmd.close_face = 1'b1;
                cmd.sort_init  = 1'b1;
                state_next     = ST_SORT_I;
            end
            ST_SORT_I: begin
                if (sts.i_done) begin
                    cmd.id_init = 1'b1;
                    state_next  = ST_ID_RD;
                end else begin
                    cmd.sort_rd_i = 1'b1;
                    state_next    = ST_SORT_K;
                end
            end
            ST_SORT_K: begin
                cmd.sort_take = 1'b1;
                state_next    = ST_SORT_RD;
            end
            ST_SORT_RD: begin
                if (sts.j_zero) begin
                    cmd.sort_place = 1'b1;
                    state_next     = ST_SORT_I;
                end else begin
                    cmd.sort_rd_j = 1'b1;
                    state_next    = ST_SORT_CMP;
                end
            end
            ST_SORT_CMP: begin
                if (sts.greater) begin
                    cmd.sort_shift = 1'b1;
                    state_next     = ST_SORT_RD;
                end else begin
                    cmd.sort_place = 1'b1;
                    state_next     = ST_SORT_I;
                end
            end
            ST_ID_RD: begin
                if (sts.i_done) begin
                    cmd.clr_init = 1'b1;
                    state_next   = ST_CLR;
                end else begin
                    cmd.id_rd  = 1'b1;
                    state_next = ST_ID_WR;
                end
            end
            ST_ID_WR: begin
                cmd.id_wr  = 1'b1;
                state_next = ST_ID_RD;
            end
            ST_CLR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    cmd.serve_init = 1'b1;
                    phase_next     = PH_EDGES;
                    state_next     = ST_ED_CHK;
                end
            end
            ST_ED_CHK: begin
                if (sts.ed_avail) begin
                    cmd.ed_rd  = 1'b1;
                    state_next = ST_ED_OUT;
                end else begin
                    cmd.rp_clear = 1'b1;
                    phase_next   = PH_ENTRIES;
                    state_next   = ST_EN_CHK;
                end
            end
            ST_ED_OUT: begin
                if (sts.out_free) begin
                    cmd.ed_out = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_EN_CHK: begin
                if (sts.en_avail) begin
                    cmd.en_rd  = 1'b1;
                    state_next = ST_EN_F;
                end else begin
                    phase_next = PH_DONE;
                    state_next = ST_DN_OUT;
                end
            end
            ST_EN_F: begin
                cmd.en_fill_rd = 1'b1;
                state_next     = ST_EN_OUT;
            end
            ST_EN_OUT: begin
                if (sts.out_free) begin
                    cmd.en_out = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_DN_OUT: begin
                if (sts.out_free) begin
                    cmd.dn_out = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                s_ready = 1'b1;
                if (s_valid && (s_kind == meue_pkg::KIND_PULL)) begin
                    case (phase_reg)
                        PH_EDGES:   state_next = ST_ED_CHK;
                        PH_ENTRIES: state_next = ST_EN_CHK;
                        default:    state_next = ST_DN_OUT;
                    endcase
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            phase_reg <= PH_EDGES;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_load2_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD2) |=> (state_reg == ST_LOAD))
        else $error("second record step did not return to loading");
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> ((state_reg == ST_LOAD) || (state_reg == ST_WAIT)))
        else $error("input taken while busy");
    a_out_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.ed_out, cmd.en_out, cmd.dn_out}) <= 1)
        else $error("two result loads at once");
`endif

endmodule
